### hw/rtl/fsbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsbf_pkg;
  localparam int unsigned ClientSlots = 16;
  localparam int unsigned BanSlots = 16;

  localparam logic [1:0] FuncConnect = 2'd0;
  localparam logic [1:0] FuncMessage = 2'd1;
  localparam logic [1:0] FuncDisconnect = 2'd2;
  localparam logic [1:0] FuncInvalid = 2'd3;

  localparam logic [2:0] VAccepted = 3'd0;
  localparam logic [2:0] VRefusedBanned = 3'd1;
  localparam logic [2:0] VRefusedFull = 3'd2;
  localparam logic [2:0] VForward = 3'd3;
  localparam logic [2:0] VStrike = 3'd4;
  localparam logic [2:0] VBannedNow = 3'd5;
  localparam logic [2:0] VUnknown = 3'd6;
  localparam logic [2:0] VRemoved = 3'd7;

  localparam logic [1:0] CfgInterval = 2'd0;
  localparam logic [1:0] CfgLimit = 2'd1;
  localparam logic [1:0] CfgDuration = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] conn_id;
    logic [31:0] ip_addr;
    logic [31:0] now_secs;
  } req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] remaining_secs;
    logic [7:0]  strikes_now;
    logic        ban_not_stored;
  } rsp_t;
endpackage
`default_nettype wire

### hw/rtl/flood_strike_ban_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Connection event filter with per-client rate limit and address bans.
// Requests arrive on req_valid_i/req_i and are taken when req_stall_o is
// low; one result per request leaves on rsp_valid_o/rsp_o and is taken
// when rsp_stall_i is low. The block handles one request at a time.
// A request walks the ban table and the client table one entry at a time
// through a single registered-read memory port per table. The longest case
// is a message that bans, which scans the client table and then the ban table;
// a connect scans the ban table and then the client table; other messages and
// disconnects scan at most the client table. The next request is taken only
// after the result has been taken.
// Registers are written on cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; write only while idle. Reset clears all valid bits and the
// registers go to interval 1, limit 10, duration 600 seconds.
// While rsp_stall_i is high the result holds and no new request is taken.
// Table storage is undefined after reset; only valid entries are used.
module flood_strike_ban_filter #(
  parameter int unsigned CLIENT_SLOTS = fsbf_pkg::ClientSlots,
  parameter int unsigned BAN_SLOTS = fsbf_pkg::BanSlots
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire fsbf_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output fsbf_pkg::rsp_t      rsp_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);
  localparam int unsigned CW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int unsigned BW = (BAN_SLOTS > 1) ? $clog2(BAN_SLOTS) : 1;
  localparam int unsigned CD = 1 << CW;
  localparam int unsigned BD = 1 << BW;
  localparam int unsigned CEW = 16 + 32 + 32 + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_BSCAN, S_BCHK, S_CSCAN, S_CCHK, S_CWR, S_MSG, S_MWR,
    S_B2SCAN, S_B2CHK, S_BWR, S_OUT
  } state_e;

  state_e state_q;
  fsbf_pkg::req_t r_q;
  logic [15:0] intv_q;
  logic [7:0]  lim_q;
  logic [31:0] dur_q;
  logic [CLIENT_SLOTS-1:0] cval_q;
  logic [BAN_SLOTS-1:0]    bval_q;
  logic [CW:0] ci_q;
  logic [BW:0] bi_q;
  logic [CW-1:0] cfree_q, chit_q;
  logic cfree_ok_q, chit_ok_q;
  logic [BW-1:0] bfree_q, bhit_q;
  logic bfree_ok_q, bhit_ok_q;
  logic [CW-1:0] cptr_q;
  logic [BW-1:0] bptr_q;
  logic [31:0] ban_addr_q;
  logic [7:0]  stk_q;
  fsbf_pkg::rsp_t rsp_q;
  logic out_q;

  // client memory: conn, addr, last, strikes
  logic c_we;
  logic [CW-1:0] c_wa;
  logic [CEW-1:0] c_wd, c_rd;
  logic b_we;
  logic [BW-1:0] b_wa;
  logic [63:0] b_wd, b_rd;

  fsbf_ram #(.Width(CEW), .Depth(CD)) u_cram (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd),
    .raddr_i(cptr_q), .rdata_o(c_rd)
  );
  fsbf_ram #(.Width(64), .Depth(BD)) u_bram (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd),
    .raddr_i(bptr_q), .rdata_o(b_rd)
  );

  wire [15:0] rd_conn = c_rd[CEW-1 -: 16];
  wire [31:0] rd_addr = c_rd[71:40];
  wire [31:0] rd_last = c_rd[39:8];
  wire [7:0]  rd_stk  = c_rd[7:0];
  wire [31:0] rd_baddr = b_rd[63:32];
  wire [31:0] rd_btime = b_rd[31:0];

  // shared subtract unit
  logic [31:0] sub_a, sub_b, sub_y;
  assign sub_y = sub_a - sub_b;
  always_comb begin
    sub_a = r_q.now_secs;
    sub_b = (state_q == S_BCHK) ? rd_btime : rd_last;
  end
  wire [31:0] rem = dur_q - sub_y;

  assign req_stall_o = (state_q != S_IDLE) || out_q;
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = out_q;
  assign rsp_o = rsp_q;

  wire [7:0] stk_inc = (rd_stk == 8'hFF) ? rd_stk : rd_stk + 8'd1;

  always_comb begin
    c_we = 1'b0;
    c_wa = chit_ok_q ? chit_q : cfree_q;
    c_wd = {r_q.conn_id, r_q.ip_addr, r_q.now_secs, 8'd0};
    b_we = 1'b0;
    b_wa = bhit_ok_q ? bhit_q : bfree_q;
    b_wd = {ban_addr_q, r_q.now_secs};
    if (state_q == S_CWR) c_we = 1'b1;
    if (state_q == S_MWR) begin
      c_we = 1'b1;
      c_wa = chit_q;
      c_wd = {rd_conn, rd_addr, (stk_q == 8'd0) ? r_q.now_secs : rd_last, stk_q};
    end
    if (state_q == S_BWR) b_we = bhit_ok_q || bfree_ok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      intv_q <= 16'd1;
      lim_q <= 8'd10;
      dur_q <= 32'd600;
      cval_q <= '0;
      bval_q <= '0;
      out_q <= 1'b0;
      ci_q <= '0;
      bi_q <= '0;
      cptr_q <= '0;
      bptr_q <= '0;
      chit_ok_q <= 1'b0;
      cfree_ok_q <= 1'b0;
      bhit_ok_q <= 1'b0;
      bfree_ok_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          fsbf_pkg::CfgInterval: intv_q <= cfg_data_i[15:0];
          fsbf_pkg::CfgLimit:    lim_q <= cfg_data_i[7:0];
          fsbf_pkg::CfgDuration: dur_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_q && !rsp_stall_i) out_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i && !req_stall_o) begin
            r_q <= req_i;
            rsp_q <= '{verdict: fsbf_pkg::VUnknown, remaining_secs: '0,
                       strikes_now: '0, ban_not_stored: 1'b0};
            ci_q <= '0; bi_q <= '0; cptr_q <= '0; bptr_q <= '0;
            chit_ok_q <= 1'b0; cfree_ok_q <= 1'b0;
            bhit_ok_q <= 1'b0; bfree_ok_q <= 1'b0;
            ban_addr_q <= req_i.ip_addr;
            unique case (req_i.func) inside
              fsbf_pkg::FuncConnect: state_q <= S_BSCAN;
              fsbf_pkg::FuncMessage, fsbf_pkg::FuncDisconnect: state_q <= S_CSCAN;
              default: begin
                out_q <= 1'b1;
              end
            endcase
          end
        end
        // ban lookup for connect: one entry per S_BSCAN/S_BCHK pass
        S_BSCAN: begin
          if (bi_q == (BW+1)'(BAN_SLOTS)) state_q <= S_CSCAN;
          else state_q <= S_BCHK;
        end
        S_BCHK: begin
          state_q <= S_BSCAN;
          bi_q <= bi_q + 1'b1;
          bptr_q <= BW'(bi_q + 1'b1);
          if (bval_q[bi_q[BW-1:0]] && rd_baddr == r_q.ip_addr) begin
            if (sub_y >= dur_q) begin
              bval_q[bi_q[BW-1:0]] <= 1'b0;
              state_q <= S_CSCAN;
            end else begin
              rsp_q.verdict <= fsbf_pkg::VRefusedBanned;
              rsp_q.remaining_secs <= rem;
              out_q <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_CSCAN: begin
          if (ci_q == (CW+1)'(CLIENT_SLOTS)) begin
            if (r_q.func == fsbf_pkg::FuncConnect) begin
              if (chit_ok_q || cfree_ok_q) state_q <= S_CWR;
              else begin
                rsp_q.verdict <= fsbf_pkg::VRefusedFull;
                out_q <= 1'b1;
                state_q <= S_IDLE;
              end
            end else begin
              out_q <= 1'b1;
              state_q <= S_IDLE;
            end
          end else state_q <= S_CCHK;
        end
        S_CCHK: begin
          state_q <= S_CSCAN;
          ci_q <= ci_q + 1'b1;
          cptr_q <= CW'(ci_q + 1'b1);
          if (!cval_q[ci_q[CW-1:0]] && !cfree_ok_q) begin
            cfree_ok_q <= 1'b1;
            cfree_q <= ci_q[CW-1:0];
          end
          if (cval_q[ci_q[CW-1:0]] && rd_conn == r_q.conn_id) begin
            chit_ok_q <= 1'b1;
            chit_q <= ci_q[CW-1:0];
            cptr_q <= ci_q[CW-1:0];
            unique case (r_q.func)
              fsbf_pkg::FuncMessage: state_q <= S_MSG;
              fsbf_pkg::FuncDisconnect: begin
                cval_q[ci_q[CW-1:0]] <= 1'b0;
                rsp_q.verdict <= fsbf_pkg::VRemoved;
                out_q <= 1'b1;
                state_q <= S_IDLE;
              end
              default: state_q <= S_CWR;
            endcase
          end
        end
        S_CWR: begin
          cval_q[c_wa] <= 1'b1;
          rsp_q.verdict <= fsbf_pkg::VAccepted;
          out_q <= 1'b1;
          state_q <= S_IDLE;
        end
        // read data of the hit slot is valid again here
        S_MSG: begin
          ban_addr_q <= rd_addr;
          if (sub_y >= {16'd0, intv_q}) begin
            stk_q <= 8'd0;
            rsp_q.verdict <= fsbf_pkg::VForward;
            state_q <= S_MWR;
          end else begin
            stk_q <= stk_inc;
            rsp_q.strikes_now <= stk_inc;
            if (stk_inc >= lim_q) begin
              cval_q[chit_q] <= 1'b0;
              rsp_q.verdict <= fsbf_pkg::VBannedNow;
              state_q <= S_B2SCAN;
            end else begin
              rsp_q.verdict <= fsbf_pkg::VStrike;
              state_q <= S_MWR;
            end
          end
        end
        S_MWR: begin
          out_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_B2SCAN: begin
          if (bi_q == (BW+1)'(BAN_SLOTS)) state_q <= S_BWR;
          else state_q <= S_B2CHK;
        end
        S_B2CHK: begin
          state_q <= S_B2SCAN;
          bi_q <= bi_q + 1'b1;
          bptr_q <= BW'(bi_q + 1'b1);
          if (!bval_q[bi_q[BW-1:0]] && !bfree_ok_q) begin
            bfree_ok_q <= 1'b1;
            bfree_q <= bi_q[BW-1:0];
          end
          if (bval_q[bi_q[BW-1:0]] && rd_baddr == ban_addr_q && !bhit_ok_q) begin
            bhit_ok_q <= 1'b1;
            bhit_q <= bi_q[BW-1:0];
          end
        end
        S_BWR: begin
          if (b_we) bval_q[b_wa] <= 1'b1;
          else rsp_q.ban_not_stored <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/fsbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fsbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### verif/tb_flood_strike_ban_filter.sv
`timescale 1ns / 1ps
module tb_flood_strike_ban_filter;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  fsbf_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  fsbf_pkg::rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  flood_strike_ban_filter u_top (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the filter state
  logic [15:0] interval_q = 16'd1;
  logic [7:0]  limit_q = 8'd10;
  logic [31:0] duration_q = 32'd600;
  logic        cl_valid [fsbf_pkg::ClientSlots];
  logic [15:0] cl_conn [fsbf_pkg::ClientSlots];
  logic [31:0] cl_addr [fsbf_pkg::ClientSlots];
  logic [31:0] cl_last [fsbf_pkg::ClientSlots];
  logic [7:0]  cl_strikes [fsbf_pkg::ClientSlots];
  logic        bn_valid [fsbf_pkg::BanSlots];
  logic [31:0] bn_addr [fsbf_pkg::BanSlots];
  logic [31:0] bn_time [fsbf_pkg::BanSlots];

  fsbf_pkg::rsp_t verdicts_due[$];
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_rsp = 1'b0;
  bit seen [8];

  function automatic int lookup_client(logic [15:0] id);
    for (int i = 0; i < fsbf_pkg::ClientSlots; i++)
      if (cl_valid[i] && cl_conn[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_ban(logic [31:0] a);
    for (int i = 0; i < fsbf_pkg::BanSlots; i++)
      if (bn_valid[i] && bn_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic fsbf_pkg::rsp_t filter_event(fsbf_pkg::req_t r);
    fsbf_pkg::rsp_t o;
    int c;
    int b;
    logic [31:0] el;
    logic banned;
    o = '0;
    o.verdict = fsbf_pkg::VUnknown;
    banned = 1'b0;
    if (r.func == fsbf_pkg::FuncConnect) begin
      b = find_ban(r.ip_addr);
      if (b >= 0) begin
        el = r.now_secs - bn_time[b];
        if (el >= duration_q) bn_valid[b] = 1'b0;
        else begin
          banned = 1'b1;
          o.remaining_secs = duration_q - el;
        end
      end
      if (banned) o.verdict = fsbf_pkg::VRefusedBanned;
      else begin
        c = lookup_client(r.conn_id);
        if (c < 0)
          for (int i = fsbf_pkg::ClientSlots - 1; i >= 0; i--) if (!cl_valid[i]) c = i;
        if (c < 0) o.verdict = fsbf_pkg::VRefusedFull;
        else begin
          cl_valid[c] = 1'b1;
          cl_conn[c] = r.conn_id;
          cl_addr[c] = r.ip_addr;
          cl_last[c] = r.now_secs;
          cl_strikes[c] = '0;
          o.verdict = fsbf_pkg::VAccepted;
        end
      end
    end else if (r.func == fsbf_pkg::FuncMessage) begin
      c = lookup_client(r.conn_id);
      if (c >= 0) begin
        el = r.now_secs - cl_last[c];
        if (el >= {16'd0, interval_q}) begin
          cl_last[c] = r.now_secs;
          cl_strikes[c] = '0;
          o.verdict = fsbf_pkg::VForward;
        end else begin
          if (cl_strikes[c] != 8'hff) cl_strikes[c]++;
          o.strikes_now = cl_strikes[c];
          if (cl_strikes[c] >= limit_q) begin
            b = find_ban(cl_addr[c]);
            if (b < 0)
              for (int i = fsbf_pkg::BanSlots - 1; i >= 0; i--) if (!bn_valid[i]) b = i;
            if (b < 0) o.ban_not_stored = 1'b1;
            else begin
              bn_valid[b] = 1'b1;
              bn_addr[b] = cl_addr[c];
              bn_time[b] = r.now_secs;
            end
            cl_valid[c] = 1'b0;
            o.verdict = fsbf_pkg::VBannedNow;
          end else o.verdict = fsbf_pkg::VStrike;
        end
      end
    end else if (r.func == fsbf_pkg::FuncDisconnect) begin
      c = lookup_client(r.conn_id);
      if (c >= 0) begin
        cl_valid[c] = 1'b0;
        o.verdict = fsbf_pkg::VRemoved;
      end
    end
    return o;
  endfunction

  // valid stays up after the accepting edge; the block stalls while busy
  task automatic send_event(logic [1:0] f, logic [15:0] id, logic [31:0] a, logic [31:0] t);
    fsbf_pkg::req_t r;
    r.func = f;
    r.conn_id = id;
    r.ip_addr = a;
    r.now_secs = t;
    while (!quiet && $urandom_range(99) < 11) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    verdicts_due.push_back(filter_event(r));
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    requests_sent++;
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      fsbf_pkg::CfgInterval: interval_q = d[15:0];
      fsbf_pkg::CfgLimit: limit_q = d[7:0];
      default: duration_q = d;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_rsp) rsp_stall_i <= 1'b1;
      else rsp_stall_i <= !quiet && ($urandom_range(99) < 11);
    end
  end

  always @(posedge clk_i) begin
    fsbf_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %p", $time, rsp_o);
      end else begin
        want = verdicts_due.pop_front();
        seen[want.verdict] = 1'b1;
        if (rsp_o.verdict !== want.verdict || rsp_o.remaining_secs !== want.remaining_secs ||
            rsp_o.strikes_now !== want.strikes_now ||
            rsp_o.ban_not_stored !== want.ban_not_stored) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, want, rsp_o);
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || (!req_valid_i && verdicts_due.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic test_directed();
    send_event(fsbf_pkg::FuncMessage, 16'hffff, 32'd0, 32'd0);
    send_event(fsbf_pkg::FuncDisconnect, 16'd5, 32'd0, 32'd0);
    send_event(fsbf_pkg::FuncInvalid, 16'd1, 32'hffffffff, 32'hffffffff);
    send_event(fsbf_pkg::FuncConnect, 16'd0, 32'h0, 32'hfffffffe);
    send_event(fsbf_pkg::FuncMessage, 16'd0, 32'h0, 32'h00000001); // wrap elapsed
    send_event(fsbf_pkg::FuncConnect, 16'd0, 32'hffffffff, 32'd10); // reconnect known id
    for (int i = 0; i < 10; i++) send_event(fsbf_pkg::FuncMessage, 16'd0, 32'd0, 32'd10);
    send_event(fsbf_pkg::FuncConnect, 16'd7, 32'hffffffff, 32'd100);
    send_event(fsbf_pkg::FuncConnect, 16'd7, 32'hffffffff, 32'd610); // expired ban
    send_event(fsbf_pkg::FuncDisconnect, 16'd7, 32'd0, 32'd610);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 17; i++)
      send_event(fsbf_pkg::FuncConnect, 16'(100 + i), 32'(i), 32'd1000);
    for (int i = 0; i < 16; i++)
      send_event(fsbf_pkg::FuncDisconnect, 16'(100 + i), 32'd0, 32'd1000);
  endtask

  task automatic test_config();
    drain();
    write_reg(fsbf_pkg::CfgInterval, 32'd0);
    write_reg(fsbf_pkg::CfgLimit, 32'd0);
    write_reg(fsbf_pkg::CfgDuration, 32'hffffffff);
    send_event(fsbf_pkg::FuncConnect, 16'd1, 32'haa, 32'd5);
    send_event(fsbf_pkg::FuncMessage, 16'd1, 32'd0, 32'd5);
    drain();
    write_reg(fsbf_pkg::CfgInterval, 32'hffff);
    write_reg(fsbf_pkg::CfgLimit, 32'd1);
    send_event(fsbf_pkg::FuncConnect, 16'd1, 32'haa, 32'd5);
    // fill ban table, then one ban that does not fit
    for (int i = 0; i < 17; i++) begin
      send_event(fsbf_pkg::FuncConnect, 16'(200 + i), 32'(5000 + i), 32'd9);
      send_event(fsbf_pkg::FuncMessage, 16'(200 + i), 32'd0, 32'd9);
    end
    drain();
    write_reg(fsbf_pkg::CfgDuration, 32'd0);
    write_reg(fsbf_pkg::CfgLimit, 32'd255);
    write_reg(fsbf_pkg::CfgInterval, 32'd3);
    send_event(fsbf_pkg::FuncConnect, 16'd1, 32'haa, 32'd20); // reconnect known id
    for (int i = 0; i < 260; i++) send_event(fsbf_pkg::FuncMessage, 16'd1, 32'd0, 32'd20);
  endtask

  task automatic test_random(int unsigned n);
    logic [31:0] clock_s;
    logic [1:0] f;
    int k;
    clock_s = $urandom;
    for (int p = 0; p < 3; p++) begin
      drain();
      write_reg(fsbf_pkg::CfgInterval, $urandom_range(4));
      write_reg(fsbf_pkg::CfgLimit, $urandom_range(1, 5));
      write_reg(fsbf_pkg::CfgDuration, $urandom_range(30));
      quiet = (p == 1);
      for (int i = 0; i < n / 3; i++) begin
        k = $urandom_range(99);
        f = k < 25 ? fsbf_pkg::FuncConnect : (k < 80 ? fsbf_pkg::FuncMessage :
            (k < 97 ? fsbf_pkg::FuncDisconnect : fsbf_pkg::FuncInvalid));
        clock_s += $urandom_range(3);
        if ($urandom_range(19) == 0)
          send_event(f, 16'($urandom), $urandom, $urandom);
        else
          send_event(f, 16'($urandom_range(20)), {$urandom_range(1) ? 8'hff : 8'h0,
                     24'($urandom_range(6))}, clock_s);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_event(fsbf_pkg::FuncMessage, 16'(i), 32'd0, 32'd0);
    join
  endtask

  initial begin
    int n;
    for (int i = 0; i < fsbf_pkg::ClientSlots; i++) cl_valid[i] = 1'b0;
    for (int i = 0; i < fsbf_pkg::BanSlots; i++) bn_valid[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_config();
    test_backpressure();
    test_random(120);
    drain();
    n = 0;
    foreach (seen[i]) n += seen[i];
    $display("Sent %0d events, checked %0d results, %0d of 8 verdict kinds seen.",
             requests_sent, results_seen, n);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
